### sv/itt_pkg.sv
package itt_pkg;

   // one input word and one result word
   typedef struct packed {
      logic       kind;
      logic [7:0] ch;
   } req_type;

   typedef struct packed {
      logic [1:0] event_res;
      logic [7:0] byte_out;
      logic [4:0] depth;
      logic       overflow;
      logic       last;
   } rsp_type;

   // status one stack cell reports to the row and to its upper neighbor
   typedef struct packed {
      logic valid;
      logic keep;
      logic wr;
   } cell_stat_type;

   localparam int LEAD_W = 16;
   localparam logic [LEAD_W-1:0] LEAD_MAX = '1;

   localparam logic KIND_BYTE = 1'b0;
   localparam logic KIND_EOI  = 1'b1;

   localparam logic [1:0] EV_NODE = 2'd0;
   localparam logic [1:0] EV_BYTE = 2'd1;
   localparam logic [1:0] EV_TEND = 2'd2;
   localparam logic [1:0] EV_EOI  = 2'd3;

   localparam logic [1:0] LP_LEAD = 2'd0;
   localparam logic [1:0] LP_TEXT = 2'd1;
   localparam logic [1:0] LP_SKIP = 2'd2;

   localparam logic [1:0] TP_GAP   = 2'd0;
   localparam logic [1:0] TP_BARE  = 2'd1;
   localparam logic [1:0] TP_QUOTE = 2'd2;

   localparam logic [7:0] CH_NL     = 8'd10;
   localparam logic [7:0] CH_SPACE  = 8'd32;
   localparam logic [7:0] CH_HASH   = 8'd35;
   localparam logic [7:0] CH_DQUOTE = 8'd34;
   localparam logic [7:0] CH_BTICK  = 8'd96;

endpackage

### sv/itt_cell.sv
module itt_cell #(
   parameter bit IS_TOP = 1'b0
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  logic                         clear,
   input  logic                         prev_keep,
   input  logic [itt_pkg::LEAD_W-1:0]   lead,
   output itt_pkg::cell_stat_type       stat
);

   logic                       valid_ff, valid_in;
   logic [itt_pkg::LEAD_W-1:0] indent_ff, indent_in;
   logic                       keep, wr;

   // survive the pop while the held indent is below the new line's indent
   assign keep = valid_ff && (indent_ff < lead);
   // take the push at the first popped slot; the top slot also takes it when full
   assign wr   = prev_keep && (!keep || IS_TOP);

   always_comb begin
      valid_in  = valid_ff;
      indent_in = indent_ff;
      if (clear) begin
         valid_in = 1'b0;
      end else if (push) begin
         valid_in = keep || wr;
         if (wr) begin
            indent_in = lead;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      indent_ff <= indent_in;
   end

   assign stat.valid = valid_ff;
   assign stat.keep  = keep;
   assign stat.wr    = wr;

endmodule

### sv/indented_text_tokenizer.sv
// Channel  Dir  Word type         Handshake
// req      in   itt_pkg::req_type req_valid / req_stall
// rsp      out  itt_pkg::rsp_type rsp_valid / rsp_stall
//
// An input word that causes two result words (node start and first token
// byte, or token end and end of input) leaves the second word in a pending
// register, and req_stall holds the next input word until it has moved on.
// The stack is a row of MAX_DEPTH cells that pop and push together. Reset is
// synchronous and clears the line state and every cell's valid bit. A stall
// on rsp holds the result word and backs up into req_stall.
module indented_text_tokenizer #(
   parameter int MAX_DEPTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  itt_pkg::req_type req_word,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output itt_pkg::rsp_type rsp_word
);

   localparam int DW = $clog2(MAX_DEPTH + 1);

   // line and token state
   logic [itt_pkg::LEAD_W-1:0] lead_ff, lead_in;
   logic [1:0]                 line_ff, line_in;
   logic [1:0]                 tok_ff, tok_in;
   logic [7:0]                 quote_ff, quote_in;
   logic [DW-1:0]              depth_ff, depth_in;

   // result register plus pending slot for the second word of an item
   logic             rsp_valid_ff, rsp_valid_in;
   itt_pkg::rsp_type rsp_word_ff, rsp_word_in;
   logic             pend_valid_ff, pend_valid_in;
   itt_pkg::rsp_type pend_word_ff, pend_word_in;

   // stack row
   itt_pkg::cell_stat_type cstat [MAX_DEPTH];
   logic [MAX_DEPTH-1:0]   cvalid;
   logic                   push, clear;
   logic [DW-1:0]          new_depth;
   logic                   ovf;

   // per-item decode
   logic             accept, out_free, blank, is_quote;
   logic [1:0]       n_res;
   itt_pkg::rsp_type r0, r1;
   logic [4:0]       cur_dep, node_dep;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = pend_valid_ff || !out_free;
   assign accept    = req_valid && !req_stall;

   assign blank    = req_word.ch <= itt_pkg::CH_SPACE;
   assign is_quote = (req_word.ch == itt_pkg::CH_DQUOTE) || (req_word.ch == itt_pkg::CH_BTICK);

   // ---------------------------------------------------------------------
   // Indentation stack: each cell hands its keep flag to the cell above, so
   // the pop and the push point settle along the row in one pass.
   // ---------------------------------------------------------------------
   genvar g;
   generate
      for (g = 0; g < MAX_DEPTH; g++) begin : g_cell
         logic prev_keep;
         if (g == 0) begin : g_first
            assign prev_keep = 1'b1;
         end else begin : g_rest
            assign prev_keep = cstat[g-1].keep;
         end
         itt_cell #(
            .IS_TOP (g == MAX_DEPTH - 1)
         ) u_cell (
            .clock     (clock),
            .reset     (reset),
            .push      (push),
            .clear     (clear),
            .prev_keep (prev_keep),
            .lead      (lead_ff),
            .stat      (cstat[g])
         );
         assign cvalid[g] = cstat[g].valid;
      end
   endgenerate

   // stack full: every entry survives and the top one gets overwritten
   assign ovf = cstat[MAX_DEPTH-1].keep;

   // encode the one-hot push point into the new node's depth
   always_comb begin
      new_depth = '0;
      for (int i = 0; i < MAX_DEPTH; i++) begin
         if (cstat[i].wr) begin
            new_depth = new_depth | DW'(i + 1);
         end
      end
   end

   assign cur_dep  = 5'(depth_ff);
   assign node_dep = 5'(new_depth);

   // ---------------------------------------------------------------------
   // Line and token sequencing for one accepted word
   // ---------------------------------------------------------------------
   always_comb begin
      lead_in  = lead_ff;
      line_in  = line_ff;
      tok_in   = tok_ff;
      quote_in = quote_ff;
      depth_in = depth_ff;
      push     = 1'b0;
      clear    = 1'b0;
      n_res    = 2'd0;
      r0       = '0;
      r1       = '0;

      if (accept) begin
         if (req_word.kind == itt_pkg::KIND_EOI) begin
            // close any open token, report end of input, start afresh
            if (line_ff == itt_pkg::LP_TEXT && tok_ff != itt_pkg::TP_GAP) begin
               r0.event_res = itt_pkg::EV_TEND;
               r0.depth     = cur_dep;
               r1.event_res = itt_pkg::EV_EOI;
               n_res        = 2'd2;
            end else begin
               r0.event_res = itt_pkg::EV_EOI;
               n_res        = 2'd1;
            end
            clear    = 1'b1;
            lead_in  = '0;
            line_in  = itt_pkg::LP_LEAD;
            tok_in   = itt_pkg::TP_GAP;
            quote_in = '0;
            depth_in = '0;
         end else if (req_word.ch == itt_pkg::CH_NL) begin
            if (line_ff == itt_pkg::LP_TEXT && tok_ff != itt_pkg::TP_GAP) begin
               r0.event_res = itt_pkg::EV_TEND;
               r0.depth     = cur_dep;
               n_res        = 2'd1;
            end
            lead_in = '0;
            line_in = itt_pkg::LP_LEAD;
            tok_in  = itt_pkg::TP_GAP;
         end else begin
            unique case (line_ff)
               itt_pkg::LP_LEAD: begin
                  if (blank) begin
                     if (lead_ff != itt_pkg::LEAD_MAX) begin
                        lead_in = lead_ff + 1'b1;
                     end
                  end else if (req_word.ch == itt_pkg::CH_HASH) begin
                     line_in = itt_pkg::LP_SKIP;
                  end else begin
                     // open a node, then open the first token
                     push         = 1'b1;
                     depth_in     = new_depth;
                     r0.event_res = itt_pkg::EV_NODE;
                     r0.depth     = node_dep;
                     r0.overflow  = ovf;
                     line_in      = itt_pkg::LP_TEXT;
                     if (is_quote) begin
                        quote_in = req_word.ch;
                        tok_in   = itt_pkg::TP_QUOTE;
                        n_res    = 2'd1;
                     end else begin
                        tok_in       = itt_pkg::TP_BARE;
                        r1.event_res = itt_pkg::EV_BYTE;
                        r1.byte_out  = req_word.ch;
                        r1.depth     = node_dep;
                        n_res        = 2'd2;
                     end
                  end
               end
               itt_pkg::LP_TEXT: begin
                  unique case (tok_ff)
                     itt_pkg::TP_BARE: begin
                        r0.depth = cur_dep;
                        n_res    = 2'd1;
                        if (blank) begin
                           r0.event_res = itt_pkg::EV_TEND;
                           tok_in       = itt_pkg::TP_GAP;
                        end else begin
                           r0.event_res = itt_pkg::EV_BYTE;
                           r0.byte_out  = req_word.ch;
                        end
                     end
                     itt_pkg::TP_QUOTE: begin
                        r0.depth = cur_dep;
                        n_res    = 2'd1;
                        if (req_word.ch == quote_ff) begin
                           r0.event_res = itt_pkg::EV_TEND;
                           tok_in       = itt_pkg::TP_GAP;
                        end else begin
                           r0.event_res = itt_pkg::EV_BYTE;
                           r0.byte_out  = req_word.ch;
                        end
                     end
                     default: begin
                        // between tokens: a non-blank byte opens the next one
                        if (!blank) begin
                           if (is_quote) begin
                              quote_in = req_word.ch;
                              tok_in   = itt_pkg::TP_QUOTE;
                           end else begin
                              tok_in       = itt_pkg::TP_BARE;
                              r0.event_res = itt_pkg::EV_BYTE;
                              r0.byte_out  = req_word.ch;
                              r0.depth     = cur_dep;
                              n_res        = 2'd1;
                           end
                        end
                     end
                  endcase
               end
               default: begin
                  // comment line: drop bytes until newline
               end
            endcase
         end
      end

      r0.last = (n_res == 2'd1);
      r1.last = 1'b1;
   end

   // ---------------------------------------------------------------------
   // Result register and pending slot
   // ---------------------------------------------------------------------
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_word_in   = rsp_word_ff;
      pend_valid_in = pend_valid_ff;
      pend_word_in  = pend_word_ff;
      if (accept) begin
         rsp_valid_in  = (n_res != 2'd0);
         rsp_word_in   = r0;
         pend_valid_in = (n_res == 2'd2);
         pend_word_in  = r1;
      end else if (out_free) begin
         // advance the pending word into the result register
         rsp_valid_in  = pend_valid_ff;
         rsp_word_in   = pend_word_ff;
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lead_ff       <= '0;
         line_ff       <= itt_pkg::LP_LEAD;
         tok_ff        <= itt_pkg::TP_GAP;
         quote_ff      <= '0;
         depth_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         lead_ff       <= lead_in;
         line_ff       <= line_in;
         tok_ff        <= tok_in;
         quote_ff      <= quote_in;
         depth_ff      <= depth_in;
         rsp_valid_ff  <= rsp_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
      rsp_word_ff  <= rsp_word_in;
      pend_word_ff <= pend_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   // a pending word never sits behind an empty result register
   a_pend_behind: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> rsp_valid_ff)
      else $error("pending word without result word");

   // the live stack entries stay packed at the bottom of the row
   a_stack_packed: assert property (@(posedge clock) disable iff (reset)
      (cvalid & (cvalid + 1'b1)) == '0)
      else $error("stack cells not contiguous");

   // a token is open only on a content line
   a_tok_line: assert property (@(posedge clock) disable iff (reset)
      tok_ff != itt_pkg::TP_GAP |-> line_ff == itt_pkg::LP_TEXT)
      else $error("token open outside content line");

   // overflow shows only on a node start
   a_ovf_node: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_word_ff.overflow |-> rsp_word_ff.event_res == itt_pkg::EV_NODE)
      else $error("overflow on non-node word");

endmodule

### test/tb_indented_text_tokenizer.sv
`timescale 1ns / 1ps

module tb_indented_text_tokenizer;

   localparam int STACK_DEPTH    = 16;
   localparam int IDLE_LIMIT     = 2000;
   localparam int HOLDOFF_CYCLES = 400;
   localparam int HOLDOFF_AFTER  = 100;
   localparam int DRAIN_CYCLES   = 20;
   localparam int RANDOM_WORDS   = 850;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   itt_pkg::req_type req_word  = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   itt_pkg::rsp_type rsp_word;

   indented_text_tokenizer #(.MAX_DEPTH(STACK_DEPTH)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_word (req_word),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_word (rsp_word)
   );

   always #10 clock = ~clock;

   // text words waiting for the driver, and the token events still owed by the block
   itt_pkg::req_type text_words[$];
   itt_pkg::rsp_type due_events[$];
   itt_pkg::rsp_type step_events[$];

   int  words_queued = 0;
   int  words_in     = 0;
   int  events_out   = 0;
   int  mismatches   = 0;
   logic req_taken   = 1'b0;

   // tokenizer state as the predictor sees it
   logic [itt_pkg::LEAD_W-1:0] lead_cnt;
   logic [1:0]                 line_ph;
   logic [1:0]                 tok_ph;
   logic [7:0]                 close_quote;
   logic [itt_pkg::LEAD_W-1:0] indents[STACK_DEPTH];
   int unsigned                open_nodes;
   logic [4:0]                 node_depth;

   function automatic void clear_tokenizer();
      lead_cnt    = '0;
      line_ph     = itt_pkg::LP_LEAD;
      tok_ph      = itt_pkg::TP_GAP;
      close_quote = '0;
      open_nodes  = 0;
      node_depth  = '0;
   endfunction

   function automatic logic is_blank(logic [7:0] c);
      return c <= itt_pkg::CH_SPACE;
   endfunction

   function automatic void note_event(logic [1:0] ev, logic [7:0] b, logic ovf);
      itt_pkg::rsp_type r;
      r.event_res = ev;
      r.byte_out  = b;
      r.depth     = (ev == itt_pkg::EV_EOI) ? 5'd0 : node_depth;
      r.overflow  = ovf;
      r.last      = 1'b0;
      step_events = {step_events, r};
   endfunction

   // a quote opens a quoted token silently; anything else is the first bare byte
   function automatic void start_token(logic [7:0] c);
      if (c == itt_pkg::CH_DQUOTE || c == itt_pkg::CH_BTICK) begin
         close_quote = c;
         tok_ph      = itt_pkg::TP_QUOTE;
      end else begin
         tok_ph = itt_pkg::TP_BARE;
         note_event(itt_pkg::EV_BYTE, c, 1'b0);
      end
   endfunction

   // work out the events one accepted text word causes and queue them
   function automatic void tokenize(itt_pkg::req_type w);
      logic ovf;
      step_events.delete();
      if (w.kind == itt_pkg::KIND_EOI) begin
         // close any open token, report end of input, start a fresh stream
         if (line_ph == itt_pkg::LP_TEXT && tok_ph != itt_pkg::TP_GAP)
            note_event(itt_pkg::EV_TEND, 8'd0, 1'b0);
         note_event(itt_pkg::EV_EOI, 8'd0, 1'b0);
         clear_tokenizer();
      end else if (w.ch == itt_pkg::CH_NL) begin
         if (line_ph == itt_pkg::LP_TEXT && tok_ph != itt_pkg::TP_GAP)
            note_event(itt_pkg::EV_TEND, 8'd0, 1'b0);
         line_ph  = itt_pkg::LP_LEAD;
         tok_ph   = itt_pkg::TP_GAP;
         lead_cnt = '0;
      end else if (line_ph == itt_pkg::LP_LEAD) begin
         if (is_blank(w.ch)) begin
            if (lead_cnt != itt_pkg::LEAD_MAX) lead_cnt++;
         end else if (w.ch == itt_pkg::CH_HASH) begin
            line_ph = itt_pkg::LP_SKIP;
         end else begin
            // pop every open node at least as deep as this line, then push it
            ovf = 1'b0;
            while (open_nodes > 0 && indents[open_nodes-1] >= lead_cnt) open_nodes--;
            if (open_nodes < STACK_DEPTH) begin
               indents[open_nodes] = lead_cnt;
               open_nodes++;
            end else begin
               // stack full: overwrite the top entry and flag it
               indents[STACK_DEPTH-1] = lead_cnt;
               ovf = 1'b1;
            end
            node_depth = open_nodes[4:0];
            note_event(itt_pkg::EV_NODE, 8'd0, ovf);
            line_ph = itt_pkg::LP_TEXT;
            start_token(w.ch);
         end
      end else if (line_ph == itt_pkg::LP_TEXT) begin
         if (tok_ph == itt_pkg::TP_BARE) begin
            if (is_blank(w.ch)) begin
               note_event(itt_pkg::EV_TEND, 8'd0, 1'b0);
               tok_ph = itt_pkg::TP_GAP;
            end else begin
               note_event(itt_pkg::EV_BYTE, w.ch, 1'b0);
            end
         end else if (tok_ph == itt_pkg::TP_QUOTE) begin
            if (w.ch == close_quote) begin
               note_event(itt_pkg::EV_TEND, 8'd0, 1'b0);
               tok_ph = itt_pkg::TP_GAP;
            end else begin
               note_event(itt_pkg::EV_BYTE, w.ch, 1'b0);
            end
         end else if (!is_blank(w.ch)) begin
            start_token(w.ch);
         end
      end
      if (step_events.size() > 0) step_events[$].last = 1'b1;
      due_events = {due_events, step_events};
   endfunction

   // stimulus helpers; called only right after a rising edge
   function automatic void push_word(itt_pkg::req_type w);
      text_words = {text_words, w};
      words_queued++;
   endfunction

   function automatic void push_byte(logic [7:0] c);
      itt_pkg::req_type w;
      w.kind = itt_pkg::KIND_BYTE;
      w.ch   = c;
      push_word(w);
   endfunction

   function automatic void push_eoi();
      itt_pkg::req_type w;
      w.kind = itt_pkg::KIND_EOI;
      w.ch   = 8'($urandom);   // ignored by the block, so scramble it
      push_word(w);
   endfunction

   function automatic void push_text(string s);
      for (int i = 0; i < s.len(); i++) push_byte(s[i]);
   endfunction

   // any blank except newline, spaces most often
   function automatic logic [7:0] blank_byte();
      logic [7:0] c;
      c = 8'($urandom_range(0, 32));
      if (c == itt_pkg::CH_NL || $urandom_range(0, 1) == 0) c = itt_pkg::CH_SPACE;
      return c;
   endfunction

   function automatic logic [7:0] solid_byte();
      return 8'($urandom_range(33, 255));
   endfunction

   task automatic flag_mismatch(string field, logic [31:0] got, logic [31:0] want);
      $display("mismatch on result %0d: %s is %0h, expected %0h",
               events_out, field, got, want);
      mismatches++;
   endtask

   // wait until every queued word went in and every owed event came out
   task automatic wait_quiet();
      do @(negedge clock); while (words_in != words_queued || due_events.size() != 0);
      @(posedge clock);
   endtask

   // Monitor: sample both handshakes at the rising edge. Predict first, so an
   // event is always owed before it could be compared.
   always @(posedge clock) begin : monitor
      itt_pkg::rsp_type due_word;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            tokenize(req_word);
            words_in++;
         end
         if (rsp_valid && !rsp_stall) begin
            events_out++;
            if (due_events.size() == 0) begin
               flag_mismatch("unexpected result word", rsp_word, 0);
            end else begin
               due_word = due_events.pop_front();
               if (rsp_word.event_res != due_word.event_res)
                  flag_mismatch("event_res", rsp_word.event_res, due_word.event_res);
               if (rsp_word.byte_out != due_word.byte_out)
                  flag_mismatch("byte_out", rsp_word.byte_out, due_word.byte_out);
               if (rsp_word.depth != due_word.depth)
                  flag_mismatch("depth", rsp_word.depth, due_word.depth);
               if (rsp_word.overflow != due_word.overflow)
                  flag_mismatch("overflow", rsp_word.overflow, due_word.overflow);
               if (rsp_word.last != due_word.last)
                  flag_mismatch("last", rsp_word.last, due_word.last);
            end
         end
      end
   end

   // Driver: change inputs at the falling edge. Hold a word until the edge
   // that takes it, then run in bursts with random gaps between them.
   int burst_left = 0;
   int gap_left   = 0;
   always @(negedge clock) begin
      if (req_valid && !req_taken) begin
         // hold the stalled word as it is
      end else if (gap_left > 0) begin
         req_valid <= 1'b0;
         gap_left--;
      end else if (text_words.size() > 0) begin
         req_valid <= 1'b1;
         req_word  <= text_words.pop_front();
         if (burst_left > 0) begin
            burst_left--;
         end else begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         end
      end else begin
         req_valid <= 1'b0;
      end
   end

   // Receiver: stall on a random pattern whose density is redrawn from time to
   // time; once, hold off for a long stretch so the block backs up.
   int  stall_pct    = 0;
   int  pattern_left = 0;
   int  holdoff_left = 0;
   logic holdoff_done = 1'b0;
   always @(negedge clock) begin
      if (holdoff_left > 0) begin
         rsp_stall <= 1'b1;
         holdoff_left--;
      end else if (!holdoff_done && events_out >= HOLDOFF_AFTER) begin
         holdoff_done = 1'b1;
         holdoff_left = HOLDOFF_CYCLES - 1;
         rsp_stall   <= 1'b1;
      end else begin
         if (pattern_left == 0) begin
            pattern_left = $urandom_range(16, 128);
            case ($urandom_range(0, 3))
               0:       stall_pct = 0;
               1:       stall_pct = 25;
               2:       stall_pct = 50;
               default: stall_pct = 85;
            endcase
         end
         pattern_left--;
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   // Watchdog: end the run when nothing moves on either channel for too long.
   int idle_cycles = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   initial begin
      int               base;
      int               segs;
      int               stairs;
      int               indent;
      int               shape;
      int               n_tok;
      int               n_ch;
      logic [7:0]       q;
      logic [7:0]       c;
      itt_pkg::req_type w;

      clear_tokenizer();
      repeat (3) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
      @(posedge clock);

      // Directed text: comment marker inside a token, comment line after a
      // NUL blank, high bytes as token characters, backtick and double quote
      // tokens, a byte right after a closing quote, a quote as the last byte
      // of a line, a blank-only line, end of input inside a token and when idle.
      push_text("x#\n");
      push_byte(8'd0);
      push_text("#c\n");
      push_text("  ");
      push_byte(8'hFF);
      push_byte(8'h80);
      push_text(" `a`b \"\n");
      push_byte(8'd0);
      push_byte(itt_pkg::CH_SPACE);
      push_byte(itt_pkg::CH_NL);
      push_text(" q");
      push_eoi();
      push_eoi();

      // pause the sender until every owed event is back
      wait_quiet();

      // random documents: mostly well-formed lines, some noise and staircases
      base   = words_queued;
      segs   = 0;
      stairs = 0;
      indent = 0;
      while (words_queued - base < RANDOM_WORDS) begin
         segs++;
         if (segs == 30 || segs == 70) begin
            // nest deeper on every line until the stack overflows
            stairs++;
            for (int lvl = 0; lvl < STACK_DEPTH + 3; lvl++) begin
               for (int i = 0; i < lvl * stairs; i++) push_byte(blank_byte());
               push_byte(8'($urandom_range(97, 122)));
               push_byte(itt_pkg::CH_NL);
            end
            indent = 0;
         end else if ($urandom_range(0, 24) == 0) begin
            // noise: raw bytes with a sprinkle of end-of-input words
            n_ch = $urandom_range(1, 8);
            for (int i = 0; i < n_ch; i++) begin
               w.kind = ($urandom_range(0, 7) == 0) ? itt_pkg::KIND_EOI : itt_pkg::KIND_BYTE;
               w.ch   = 8'($urandom);
               push_word(w);
            end
         end else begin
            case ($urandom_range(0, 3))
               0:       indent = 0;
               1:       indent = indent + $urandom_range(1, 3);
               2:       indent = (indent > 2) ? indent - $urandom_range(1, 2) : 0;
               default: ;
            endcase
            if (indent > 12) indent = 12;
            shape = $urandom_range(0, 9);
            for (int i = 0; i < indent; i++) push_byte(blank_byte());
            if (shape == 0) begin
               // blank line: the indent alone
            end else if (shape == 1) begin
               push_byte(itt_pkg::CH_HASH);
               n_ch = $urandom_range(0, 6);
               for (int i = 0; i < n_ch; i++) begin
                  c = 8'($urandom);
                  if (c == itt_pkg::CH_NL) c = itt_pkg::CH_HASH;
                  push_byte(c);
               end
            end else begin
               n_tok = $urandom_range(1, 4);
               for (int t = 0; t < n_tok; t++) begin
                  // zero blanks after a quoted token starts the next one at once
                  if (t > 0) begin
                     n_ch = $urandom_range(0, 2);
                     for (int i = 0; i < n_ch; i++) push_byte(blank_byte());
                  end
                  if ($urandom_range(0, 2) == 0) begin
                     q = ($urandom_range(0, 1) == 0) ? itt_pkg::CH_DQUOTE : itt_pkg::CH_BTICK;
                     push_byte(q);
                     n_ch = $urandom_range(0, 5);
                     for (int i = 0; i < n_ch; i++) begin
                        c = 8'($urandom);
                        if (c == itt_pkg::CH_NL || c == q) c = c ^ 8'h01;
                        push_byte(c);
                     end
                     // leave the last quoted token open now and then
                     if (t < n_tok - 1 || $urandom_range(0, 3) != 0) push_byte(q);
                  end else begin
                     c = solid_byte();
                     if (c == itt_pkg::CH_DQUOTE || c == itt_pkg::CH_BTICK ||
                         (t == 0 && c == itt_pkg::CH_HASH))
                        c = 8'h61;
                     push_byte(c);
                     n_ch = $urandom_range(0, 5);
                     for (int i = 0; i < n_ch; i++) push_byte(solid_byte());
                  end
               end
               if ($urandom_range(0, 3) == 0) push_byte(blank_byte());
            end
            if ($urandom_range(0, 29) == 0) push_eoi();
            else push_byte(itt_pkg::CH_NL);
         end
      end

      wait_quiet();
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
      if (mismatches == 0 && due_events.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
